@@ src/ffa_pkg.sv @@
`default_nettype none
package ffa_pkg;

    localparam int ARENA_SIZE_DEF    = 1048576;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int ADDR_W = 20;
    localparam int LEN_W  = 21;
    localparam int SZ_W   = 25;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_COMPACT = 2'd2;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_NO_MEM     = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND  = 2'd2;
    localparam logic [1:0] STS_TABLE_FULL = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CSTART,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic [1:0] mode;
        logic       scan_start;
        logic       alloc_commit;
        logic       free_commit;
        logic       move_commit;
        logic       compact_empty;
        logic       fail;
        logic [1:0] fail_code;
    } t_ctl;

    typedef struct packed {
        logic size_bad;
        logic used_full;
        logic free_full;
        logic found;
        logic scan_done;
        logic live_zero;
        logic more;
        logic out_done;
    } t_sts;

endpackage
`default_nettype wire

@@ src/ffa_if.sv @@
`default_nettype none
interface ffa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [20:0] request_size;
    logic [19:0] block_address;
    modport source (output valid, command, request_size, block_address, input ready);
    modport sink (input valid, command, request_size, block_address, output ready);
endinterface

interface ffa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [19:0] result_address;
    logic [19:0] old_address;
    logic [20:0] move_length;
    logic        last;
    modport source (output valid, status, result_address, old_address, move_length, last,
                    input ready);
    modport sink (input valid, status, result_address, old_address, move_length, last,
                  output ready);
endinterface
`default_nettype wire

@@ src/ffa_ctrl.sv @@
`default_nettype none
module ffa_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire [1:0]        i_command,
    output logic             o_ready,
    input  wire ffa_pkg::t_sts i_sts,
    output ffa_pkg::t_ctl    o_ctl
);
    ffa_pkg::t_state r_state, n_state;
    logic [1:0] r_cmd, n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::S_IDLE;
            r_cmd   <= ffa_pkg::CMD_ALLOC;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        o_ready = 1'b0;
        o_ctl   = '0;
        o_ctl.mode = r_cmd;
        case (r_state)
            ffa_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_cmd = i_command;
                    case (i_command)
                        ffa_pkg::CMD_ALLOC: n_state = ffa_pkg::S_CHECK;
                        ffa_pkg::CMD_FREE: begin
                            o_ctl.scan_start = 1'b1;
                            n_state = ffa_pkg::S_SCAN;
                        end
                        ffa_pkg::CMD_COMPACT: n_state = ffa_pkg::S_CSTART;
                        default: n_state = ffa_pkg::S_IDLE;
                    endcase
                end
            end
            ffa_pkg::S_CHECK: begin
                n_state = ffa_pkg::S_OUT;
                if (i_sts.size_bad) begin
                    o_ctl.fail = 1'b1;
                    o_ctl.fail_code = ffa_pkg::STS_NO_MEM;
                end else if (i_sts.used_full) begin
                    o_ctl.fail = 1'b1;
                    o_ctl.fail_code = ffa_pkg::STS_TABLE_FULL;
                end else begin
                    o_ctl.scan_start = 1'b1;
                    n_state = ffa_pkg::S_SCAN;
                end
            end
            ffa_pkg::S_CSTART: begin
                if (i_sts.live_zero) begin
                    o_ctl.compact_empty = 1'b1;
                    n_state = ffa_pkg::S_OUT;
                end else begin
                    o_ctl.scan_start = 1'b1;
                    n_state = ffa_pkg::S_SCAN;
                end
            end
            ffa_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ffa_pkg::S_OUT;
                    case (r_cmd)
                        ffa_pkg::CMD_ALLOC: begin
                            if (i_sts.found) begin
                                o_ctl.alloc_commit = 1'b1;
                            end else begin
                                o_ctl.fail = 1'b1;
                                o_ctl.fail_code = ffa_pkg::STS_NO_MEM;
                            end
                        end
                        ffa_pkg::CMD_FREE: begin
                            if (!i_sts.found) begin
                                o_ctl.fail = 1'b1;
                                o_ctl.fail_code = ffa_pkg::STS_NOT_FOUND;
                            end else if (i_sts.free_full) begin
                                o_ctl.fail = 1'b1;
                                o_ctl.fail_code = ffa_pkg::STS_TABLE_FULL;
                            end else begin
                                o_ctl.free_commit = 1'b1;
                            end
                        end
                        default: o_ctl.move_commit = 1'b1;
                    endcase
                end
            end
            ffa_pkg::S_OUT: begin
                if (i_sts.out_done) begin
                    if (r_cmd == ffa_pkg::CMD_COMPACT && i_sts.more) begin
                        o_ctl.scan_start = 1'b1;
                        n_state = ffa_pkg::S_SCAN;
                    end else begin
                        n_state = ffa_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = ffa_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ src/ffa_dp.sv @@
`default_nettype none
module ffa_dp #(
    parameter int ARENA_SIZE    = ffa_pkg::ARENA_SIZE_DEF,
    parameter int TABLE_ENTRIES = ffa_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire ffa_pkg::t_ctl            i_ctl,
    output ffa_pkg::t_sts                 o_sts,
    input  wire [ffa_pkg::LEN_W-1:0]      i_request_size,
    input  wire [ffa_pkg::ADDR_W-1:0]     i_block_address,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [1:0]                    o_status,
    output logic [ffa_pkg::ADDR_W-1:0]    o_result_address,
    output logic [ffa_pkg::ADDR_W-1:0]    o_old_address,
    output logic [ffa_pkg::LEN_W-1:0]     o_move_length,
    output logic                          o_last
);
    localparam int N  = TABLE_ENTRIES;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = IW + 1;
    localparam int W  = ffa_pkg::SZ_W;
    localparam logic [W-1:0]  ARENA_W = W'(ARENA_SIZE);
    localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

    logic [W-1:0]               m_fs [N];
    logic [W-1:0]               m_fl [N];
    logic [W-1:0]               m_us [N];
    logic [ffa_pkg::LEN_W-1:0]  m_ul [N];

    logic [ffa_pkg::LEN_W-1:0]  r_size;
    logic [ffa_pkg::ADDR_W-1:0] r_baddr;
    logic [N-1:0]               r_fv, r_uv, r_done;
    logic                       r_f0init;
    logic [W-1:0]               r_bytes, r_next;
    logic [CW-1:0]              r_left, r_live;
    logic                       r_run, r_pv, r_sdone, r_found, r_ov;
    logic [IW-1:0]              r_idx, r_raddr, r_bidx;
    logic [W-1:0]               r_fs_q, r_fl_q, r_us_q, r_bs, r_bl;
    logic [ffa_pkg::LEN_W-1:0]  r_ul_q;

    logic [W-1:0]  rd_fs, rd_fl, size_w, end_w, rem_w;
    logic          match, stop, last_entry, end_do;
    logic [IW-1:0] uidx, fidx;
    logic          used_full, free_full;
    logic          we_f, we_u;
    logic [IW-1:0] wa_f, wa_u;
    logic [W-1:0]  wd_fs, wd_fl, wd_us;
    logic [ffa_pkg::LEN_W-1:0] wd_ul;

    assign size_w = W'(r_size);
    assign rd_fs  = (r_f0init && r_raddr == '0) ? '0 : r_fs_q;
    assign rd_fl  = (r_f0init && r_raddr == '0) ? ARENA_W : r_fl_q;
    assign last_entry = (r_raddr == LAST_IDX);

    always_comb begin
        case (i_ctl.mode)
            ffa_pkg::CMD_ALLOC: match = r_fv[r_raddr] && (rd_fl >= size_w);
            ffa_pkg::CMD_FREE:  match = r_uv[r_raddr] && (r_us_q == W'(r_baddr));
            default: match = r_uv[r_raddr] && !r_done[r_raddr] &&
                             (!r_found || r_us_q < r_bs);
        endcase
        stop = (i_ctl.mode != ffa_pkg::CMD_COMPACT) && match;
    end

    always_comb begin
        uidx = '0;
        fidx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_uv[i]) uidx = IW'(i);
            if (!r_fv[i]) fidx = IW'(i);
        end
        used_full = &r_uv;
        free_full = &r_fv;
    end

    assign end_do = i_ctl.compact_empty || (i_ctl.move_commit && r_left == CW'(1));
    assign end_w  = i_ctl.compact_empty ? r_next : r_next + r_bl;
    assign rem_w  = ARENA_W - end_w;

    always_comb begin
        we_f  = 1'b0;
        wa_f  = '0;
        wd_fs = end_w;
        wd_fl = rem_w;
        we_u  = 1'b0;
        wa_u  = r_bidx;
        wd_us = r_next;
        wd_ul = r_bl[ffa_pkg::LEN_W-1:0];
        if (i_ctl.alloc_commit) begin
            we_f  = 1'b1;
            wa_f  = r_bidx;
            wd_fs = r_bs + size_w;
            wd_fl = r_bl - size_w;
            we_u  = 1'b1;
            wa_u  = uidx;
            wd_us = r_bs;
            wd_ul = r_size;
        end else if (i_ctl.free_commit) begin
            we_f  = 1'b1;
            wa_f  = fidx;
            wd_fs = r_bs;
            wd_fl = r_bl;
        end else begin
            we_f = end_do;
            we_u = i_ctl.move_commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_f) begin
            m_fs[wa_f] <= wd_fs;
            m_fl[wa_f] <= wd_fl;
        end
        if (we_u) begin
            m_us[wa_u] <= wd_us;
            m_ul[wa_u] <= wd_ul;
        end
        r_fs_q <= m_fs[r_idx];
        r_fl_q <= m_fl[r_idx];
        r_us_q <= m_us[r_idx];
        r_ul_q <= m_ul[r_idx];
        r_raddr <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_pv    <= 1'b0;
            r_sdone <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else if (i_ctl.scan_start) begin
            r_run   <= 1'b1;
            r_pv    <= 1'b0;
            r_sdone <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_sdone <= 1'b0;
            r_pv    <= r_run;
            if (r_run) begin
                r_idx <= r_idx + IW'(1);
                if (r_idx == LAST_IDX) r_run <= 1'b0;
            end
            if (r_pv) begin
                if (match) r_found <= 1'b1;
                if (stop || last_entry) begin
                    r_sdone <= 1'b1;
                    r_run   <= 1'b0;
                    r_pv    <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pv && match) begin
            r_bidx <= r_raddr;
            if (i_ctl.mode == ffa_pkg::CMD_ALLOC) begin
                r_bs <= rd_fs;
                r_bl <= rd_fl;
            end else begin
                r_bs <= r_us_q;
                r_bl <= W'(r_ul_q);
            end
        end
        if (i_ctl.load) begin
            r_size  <= i_request_size;
            r_baddr <= i_block_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv     <= N'(1);
            r_uv     <= '0;
            r_done   <= '0;
            r_f0init <= 1'b1;
            r_bytes  <= ARENA_W;
            r_next   <= '0;
            r_left   <= '0;
            r_live   <= '0;
        end else begin
            if (i_ctl.load) begin
                r_done <= '0;
                r_next <= '0;
                r_left <= r_live;
            end
            if (i_ctl.alloc_commit) begin
                r_uv[uidx] <= 1'b1;
                if (r_bl == size_w) r_fv[r_bidx] <= 1'b0;
                if (r_bidx == '0) r_f0init <= 1'b0;
                r_bytes <= r_bytes - size_w;
                r_live  <= r_live + CW'(1);
            end
            if (i_ctl.free_commit) begin
                r_uv[r_bidx] <= 1'b0;
                r_fv[fidx]   <= 1'b1;
                if (fidx == '0) r_f0init <= 1'b0;
                r_bytes <= r_bytes + r_bl;
                r_live  <= r_live - CW'(1);
            end
            if (i_ctl.move_commit) begin
                r_done[r_bidx] <= 1'b1;
                r_next <= r_next + r_bl;
                r_left <= r_left - CW'(1);
            end
            if (end_do) begin
                r_fv     <= N'(rem_w != '0);
                r_f0init <= 1'b0;
                r_bytes  <= rem_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ctl.fail || i_ctl.alloc_commit || i_ctl.free_commit ||
                     i_ctl.move_commit || i_ctl.compact_empty) begin
            r_ov <= 1'b1;
        end else if (r_ov && i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fail || i_ctl.alloc_commit || i_ctl.free_commit ||
            i_ctl.move_commit || i_ctl.compact_empty) begin
            o_status         <= i_ctl.fail ? i_ctl.fail_code : ffa_pkg::STS_OK;
            o_result_address <= '0;
            o_old_address    <= '0;
            o_move_length    <= '0;
            o_last           <= 1'b1;
            if (i_ctl.alloc_commit) o_result_address <= r_bs[ffa_pkg::ADDR_W-1:0];
            if (i_ctl.move_commit) begin
                o_result_address <= r_next[ffa_pkg::ADDR_W-1:0];
                o_old_address    <= r_bs[ffa_pkg::ADDR_W-1:0];
                o_move_length    <= r_bl[ffa_pkg::LEN_W-1:0];
                o_last           <= (r_left == CW'(1));
            end
        end
    end

    assign o_valid = r_ov;

    always_comb begin
        o_sts.size_bad  = (r_size == '0) || (size_w > ARENA_W) || (size_w > r_bytes);
        o_sts.used_full = used_full;
        o_sts.free_full = free_full;
        o_sts.found     = r_found;
        o_sts.scan_done = r_sdone;
        o_sts.live_zero = (r_left == '0);
        o_sts.more      = (r_left != '0);
        o_sts.out_done  = r_ov && i_ready;
    end
endmodule
`default_nettype wire

@@ src/first_fit_allocator_with_compaction_core.sv @@
`default_nettype none
// First-fit address allocator with compaction. Commands (allocate, free, compact)
// arrive on i_cmd; results leave on o_res. Allocate and free give one result,
// compact gives one move per live block in ascending address order (or one
// empty result), with last set on the final one. One command is handled at a
// time: each table search walks the TABLE_ENTRIES slots through one registered
// memory read port. The allocate and free searches stop at the first match, and
// an allocate with a rejected size is answered without a search; compact runs
// one search per live block. A result that waits on o_res.ready holds off the
// next command or search. Copying the data of moved blocks is left to the
// consumer.
module first_fit_allocator_with_compaction_core #(
    parameter int ARENA_SIZE    = ffa_pkg::ARENA_SIZE_DEF,
    parameter int TABLE_ENTRIES = ffa_pkg::TABLE_ENTRIES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ffa_in_if.sink     i_cmd,
    ffa_out_if.source  o_res
);
    ffa_pkg::t_ctl ctl;
    ffa_pkg::t_sts sts;

    ffa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cmd.valid),
        .i_command (i_cmd.command),
        .o_ready   (i_cmd.ready),
        .i_sts     (sts),
        .o_ctl     (ctl)
    );

    ffa_dp #(
        .ARENA_SIZE    (ARENA_SIZE),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_request_size   (i_cmd.request_size),
        .i_block_address  (i_cmd.block_address),
        .o_valid          (o_res.valid),
        .i_ready          (o_res.ready),
        .o_status         (o_res.status),
        .o_result_address (o_res.result_address),
        .o_old_address    (o_res.old_address),
        .o_move_length    (o_res.move_length),
        .o_last           (o_res.last)
    );
endmodule
`default_nettype wire

@@ tb/first_fit_allocator_with_compaction_core_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module first_fit_allocator_with_compaction_core_tb;

    localparam int ARENA   = ffa_pkg::ARENA_SIZE_DEF;
    localparam int ENTRIES = ffa_pkg::TABLE_ENTRIES_DEF;
    localparam int N_RAND  = 450;
    localparam int STALL_LIMIT = 40000;
    localparam logic [1:0] CMD_BAD = 2'd3;

    typedef struct packed {
        logic [1:0]  sts;
        logic [19:0] new_addr;
        logic [19:0] old_addr;
        logic [20:0] mlen;
        logic        last;
    } t_res;

    typedef struct {
        logic [1:0]  cmd;
        logic [20:0] size;
        logic [19:0] addr;
        bit          chk;
        logic [1:0]  sts;
        logic [19:0] res_addr;
    } t_row;

    logic clk;
    logic rst_n;
    ffa_in_if  cmd_if ();
    ffa_out_if res_if ();

    first_fit_allocator_with_compaction_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    logic [19:0] region_start [ENTRIES];
    logic [20:0] region_len   [ENTRIES];
    bit          region_vld   [ENTRIES];
    logic [19:0] blk_start    [ENTRIES];
    logic [20:0] blk_len      [ENTRIES];
    bit          blk_vld      [ENTRIES];
    int          avail;

    t_res  pending_q[$];
    t_row  dir_rows[$];
    int    errors;
    int    n_sent, n_res, n_moves, n_full, n_nomem, n_notfound;
    int    stall_cnt;
    bit    calm;
    bit    hold_req;
    bit    chk_on;
    logic [1:0]  chk_sts;
    logic [19:0] chk_addr;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("%0t ERROR %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic push_res(input logic [1:0] s, input int a, input int o, input int l,
                            input bit lst);
        t_res r;
        r.sts = s; r.new_addr = a[19:0]; r.old_addr = o[19:0];
        r.mlen = l[20:0]; r.last = lst;
        pending_q.push_back(r);
    endtask

    task automatic alloc_predict(input int size);
        int slot, reg_i, a;
        slot = -1; reg_i = -1;
        if (size == 0 || size > ARENA || size > avail) begin
            push_res(ffa_pkg::STS_NO_MEM, 0, 0, 0, 1);
            return;
        end
        for (int i = 0; i < ENTRIES; i++) if (!blk_vld[i] && slot < 0) slot = i;
        if (slot < 0) begin
            push_res(ffa_pkg::STS_TABLE_FULL, 0, 0, 0, 1);
            return;
        end
        for (int i = 0; i < ENTRIES; i++)
            if (reg_i < 0 && region_vld[i] && region_len[i] >= size) reg_i = i;
        if (reg_i < 0) begin
            push_res(ffa_pkg::STS_NO_MEM, 0, 0, 0, 1);
            return;
        end
        a = int'(region_start[reg_i]);
        blk_start[slot] = 20'(a); blk_len[slot] = 21'(size); blk_vld[slot] = 1;
        region_start[reg_i] = 20'(a + size);
        region_len[reg_i] = 21'(int'(region_len[reg_i]) - size);
        if (region_len[reg_i] == 0) region_vld[reg_i] = 0;
        avail -= size;
        push_res(ffa_pkg::STS_OK, a, 0, 0, 1);
    endtask

    task automatic free_predict(input logic [19:0] addr);
        int b, r;
        b = -1; r = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (b < 0 && blk_vld[i] && blk_start[i] == addr) b = i;
        if (b < 0) begin
            push_res(ffa_pkg::STS_NOT_FOUND, 0, 0, 0, 1);
            return;
        end
        for (int i = 0; i < ENTRIES; i++) if (r < 0 && !region_vld[i]) r = i;
        if (r < 0) begin
            push_res(ffa_pkg::STS_TABLE_FULL, 0, 0, 0, 1);
            return;
        end
        blk_vld[b] = 0;
        region_start[r] = blk_start[b]; region_len[r] = blk_len[b]; region_vld[r] = 1;
        avail += int'(blk_len[b]);
        push_res(ffa_pkg::STS_OK, 0, 0, 0, 1);
    endtask

    task automatic compact_predict();
        bit done [ENTRIES];
        int live, nxt, pick, old;
        live = 0; nxt = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            done[i] = 0;
            if (blk_vld[i]) live++;
        end
        for (int n = 0; n < live; n++) begin
            pick = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (blk_vld[i] && !done[i] && (pick < 0 || blk_start[i] < blk_start[pick]))
                    pick = i;
            done[pick] = 1;
            old = int'(blk_start[pick]);
            blk_start[pick] = nxt[19:0];
            push_res(ffa_pkg::STS_OK, nxt, old, int'(blk_len[pick]), n + 1 == live);
            nxt += int'(blk_len[pick]);
        end
        for (int i = 0; i < ENTRIES; i++) region_vld[i] = 0;
        if (nxt > ARENA) nxt = ARENA;
        region_start[0] = nxt[19:0];
        region_len[0] = 21'(ARENA - nxt);
        region_vld[0] = (ARENA - nxt) != 0;
        avail = ARENA - nxt;
        if (live == 0) push_res(ffa_pkg::STS_OK, 0, 0, 0, 1);
    endtask

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("first_fit_allocator_with_compaction_core: mismatch");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && cmd_if.valid && cmd_if.ready) begin
            int before_n;
            before_n = pending_q.size();
            case (cmd_if.command)
                ffa_pkg::CMD_ALLOC:   alloc_predict(int'(cmd_if.request_size));
                ffa_pkg::CMD_FREE:    free_predict(cmd_if.block_address);
                ffa_pkg::CMD_COMPACT: compact_predict();
                default: ;
            endcase
            if (chk_on) begin
                if (pending_q.size() == before_n)
                    report("directed row gave no result", 0, 1);
                else if (pending_q[before_n].sts !== chk_sts ||
                         pending_q[before_n].new_addr !== chk_addr)
                    report("directed row status/address",
                           {pending_q[before_n].sts, pending_q[before_n].new_addr},
                           {chk_sts, chk_addr});
            end
        end
        if (rst_n && res_if.valid && res_if.ready) begin
            t_res want;
            n_res++;
            if (pending_q.size() == 0) begin
                report("unexpected result status", res_if.status, 0);
            end else begin
                want = pending_q.pop_front();
                if (res_if.move_length != 0) n_moves++;
                if (res_if.status === ffa_pkg::STS_TABLE_FULL) n_full++;
                if (res_if.status === ffa_pkg::STS_NO_MEM) n_nomem++;
                if (res_if.status === ffa_pkg::STS_NOT_FOUND) n_notfound++;
                if (res_if.status !== want.sts) report("status", res_if.status, want.sts);
                if (res_if.result_address !== want.new_addr)
                    report("result_address", res_if.result_address, want.new_addr);
                if (res_if.old_address !== want.old_addr)
                    report("old_address", res_if.old_address, want.old_addr);
                if (res_if.move_length !== want.mlen)
                    report("move_length", res_if.move_length, want.mlen);
                if (res_if.last !== want.last) report("last", res_if.last, want.last);
            end
        end
    end

    initial begin
        res_if.ready = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                res_if.ready <= 0;
                repeat (600) @(posedge clk);
                hold_req = 0;
            end else if (calm) begin
                res_if.ready <= 1;
                @(posedge clk);
            end else if ($urandom_range(0, 2) == 0) begin
                res_if.ready <= 0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end else begin
                res_if.ready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send(input logic [1:0] c, input logic [20:0] s, input logic [19:0] a,
                        input bit chk, input logic [1:0] es, input logic [19:0] ea);
        if (!calm && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        cmd_if.valid <= 1;
        cmd_if.command <= c;
        cmd_if.request_size <= s;
        cmd_if.block_address <= a;
        chk_on <= chk;
        chk_sts <= es;
        chk_addr <= ea;
        do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
        n_sent++;
    endtask

    function automatic logic [19:0] live_addr();
        int idx[$];
        for (int i = 0; i < ENTRIES; i++) if (blk_vld[i]) idx.push_back(i);
        if (idx.size() == 0) return 20'($urandom);
        return blk_start[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    initial begin
        logic [1:0]  c;
        logic [20:0] s;
        logic [19:0] a;
        int pick, fragging;
        errors = 0; n_sent = 0; n_res = 0; n_moves = 0; n_full = 0;
        n_nomem = 0; n_notfound = 0; stall_cnt = 0; calm = 0; hold_req = 0;
        chk_on = 0; chk_sts = 0; chk_addr = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            region_start[i] = 0; region_len[i] = 0; region_vld[i] = 0;
            blk_start[i] = 0; blk_len[i] = 0; blk_vld[i] = 0;
        end
        region_len[0] = 21'(ARENA); region_vld[0] = 1; avail = ARENA;
        cmd_if.valid = 0; cmd_if.command = ffa_pkg::CMD_ALLOC;
        cmd_if.request_size = 0; cmd_if.block_address = 0;
        rst_n = 0;

        dir_rows = '{
            '{ffa_pkg::CMD_ALLOC,   21'd0,       20'd0,     1, ffa_pkg::STS_NO_MEM,    20'd0},
            '{ffa_pkg::CMD_ALLOC,   21'h1FFFFF,  20'd0,     1, ffa_pkg::STS_NO_MEM,    20'd0},
            '{ffa_pkg::CMD_ALLOC,   21'd1048577, 20'd0,     1, ffa_pkg::STS_NO_MEM,    20'd0},
            '{ffa_pkg::CMD_COMPACT, 21'd0,       20'd0,     1, ffa_pkg::STS_OK,        20'd0},
            '{ffa_pkg::CMD_FREE,    21'd0,       20'hFFFFF, 1, ffa_pkg::STS_NOT_FOUND, 20'd0},
            '{ffa_pkg::CMD_ALLOC,   21'd1048576, 20'd0,     1, ffa_pkg::STS_OK,        20'd0},
            '{ffa_pkg::CMD_ALLOC,   21'd1,       20'd0,     1, ffa_pkg::STS_NO_MEM,    20'd0},
            '{ffa_pkg::CMD_COMPACT, 21'd0,       20'd0,     1, ffa_pkg::STS_OK,        20'd0},
            '{CMD_BAD,              21'h1FFFFF,  20'hFFFFF, 0, ffa_pkg::STS_OK,        20'd0},
            '{ffa_pkg::CMD_FREE,    21'h1FFFFF,  20'd0,     1, ffa_pkg::STS_OK,        20'd0},
            '{ffa_pkg::CMD_ALLOC,   21'd100,     20'd0,     1, ffa_pkg::STS_OK,        20'd0},
            '{ffa_pkg::CMD_ALLOC,   21'd200,     20'd0,     1, ffa_pkg::STS_OK,        20'd100},
            '{ffa_pkg::CMD_ALLOC,   21'd300,     20'd0,     1, ffa_pkg::STS_OK,        20'd300},
            '{ffa_pkg::CMD_FREE,    21'd0,       20'd100,   1, ffa_pkg::STS_OK,        20'd0},
            '{ffa_pkg::CMD_ALLOC,   21'd150,     20'd0,     1, ffa_pkg::STS_OK,        20'd600},
            '{ffa_pkg::CMD_ALLOC,   21'd50,      20'd0,     1, ffa_pkg::STS_OK,        20'd750},
            '{ffa_pkg::CMD_ALLOC,   21'd1048000, 20'd0,     1, ffa_pkg::STS_NO_MEM,    20'd0},
            '{ffa_pkg::CMD_FREE,    21'd0,       20'd101,   1, ffa_pkg::STS_NOT_FOUND, 20'd0},
            '{ffa_pkg::CMD_COMPACT, 21'd0,       20'd0,     0, ffa_pkg::STS_OK,        20'd0},
            '{ffa_pkg::CMD_ALLOC,   21'd1047976, 20'd0,     0, ffa_pkg::STS_OK,        20'd0},
            '{ffa_pkg::CMD_COMPACT, 21'd0,       20'd0,     0, ffa_pkg::STS_OK,        20'd0},
            '{ffa_pkg::CMD_ALLOC,   21'd1,       20'd0,     1, ffa_pkg::STS_NO_MEM,    20'd0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (dir_rows[i])
            send(dir_rows[i].cmd, dir_rows[i].size, dir_rows[i].addr,
                 dir_rows[i].chk, dir_rows[i].sts, dir_rows[i].res_addr);
        send(ffa_pkg::CMD_COMPACT, 0, 0, 0, ffa_pkg::STS_OK, 0);
        for (int i = 0; i < 4; i++)
            send(ffa_pkg::CMD_FREE, 0, live_addr(), 0, ffa_pkg::STS_OK, 0);

        fragging = 0;
        for (int n = 0; n < N_RAND; n++) begin
            if (n == 150) hold_req = 1;
            if (n == 400) calm = 1;
            if (n % 120 == 60) fragging = 90;
            a = 20'($urandom);
            s = 21'($urandom_range(1, 4096));
            if (fragging > 0) begin
                fragging--;
                c = (fragging % 3 == 0) ? ffa_pkg::CMD_FREE : ffa_pkg::CMD_ALLOC;
                s = 21'($urandom_range(1, 64));
                if (c == ffa_pkg::CMD_FREE) a = live_addr();
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    c = ffa_pkg::CMD_ALLOC;
                    if ($urandom_range(0, 9) == 0) s = 21'($urandom);
                    else if ($urandom_range(0, 9) == 0) s = 21'($urandom_range(1, avail + 1));
                end else if (pick < 88) begin
                    c = ffa_pkg::CMD_FREE;
                    if ($urandom_range(0, 4) != 0) a = live_addr();
                end else if (pick < 96) begin
                    c = ffa_pkg::CMD_COMPACT;
                end else begin
                    c = CMD_BAD;
                end
            end
            send(c, s, a, 0, ffa_pkg::STS_OK, 0);
        end
        cmd_if.valid <= 0;
        chk_on <= 0;

        while (pending_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("sent %0d commands, checked %0d results (%0d moves)", n_sent, n_res, n_moves);
        $display("out of memory %0d, unknown block %0d, table full %0d",
                 n_nomem, n_notfound, n_full);
        if (errors == 0 && pending_q.size() == 0)
            $display("first_fit_allocator_with_compaction_core: match");
        else
            $display("first_fit_allocator_with_compaction_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
